// ----- hw/rtl/index_merge_sort_macros.svh -----
// Assertion macros shared by the argsort engine RTL.
`ifndef INDEX_MERGE_SORT_MACROS_SVH
`define INDEX_MERGE_SORT_MACROS_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define IMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define IMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ims_pkg.sv -----
// Shared types and constants of the argsort engine.
`timescale 1ns / 1ps
package ims_pkg;
	localparam int MaxElements = 64;
	localparam int KeyBits = 16;

	typedef struct packed {
		logic [15:0] key;
		logic        last_key;
	} in_item_t;

	typedef struct packed {
		logic [5:0] position;
		logic       last_position;
	} out_item_t;

	typedef struct packed {
		logic key_wr;
		logic clr_i;
		logic inc_i;
		logic clr_j;
		logic inc_j;
		logic rd_i;
		logic rd_j;
		logic load_cur;
		logic clr_rank;
		logic pos_wr;
		logic clr_k;
		logic inc_k;
		logic out_rd;
		logic clr_count;
	} cmd_t;

	typedef struct packed {
		logic i_end;
		logic j_end;
		logic k_end;
	} status_t;
endpackage

// ----- hw/rtl/index_merge_sort.sv -----
// Top level of the argsort engine.
`timescale 1ns / 1ps
`include "index_merge_sort_macros.svh"
// Keys are loaded one per cycle while busy is low; the transfer with last_key set closes the
// set. The block then ranks each key by a full sweep over the key memory, so the sort time
// is set by the single read port of the key memory. After that one position per cycle comes
// out on result, marked by result_valid, one for each key, and busy falls once the last
// position has come out. The receiver cannot stall, so results must be taken as they appear.
// Keys beyond MAX_ELEMENTS are dropped.
module index_merge_sort import ims_pkg::*; #(
	parameter int MAX_ELEMENTS = MaxElements,
	parameter int KEY_BITS = KeyBits
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output out_item_t result,
	output logic      result_valid
);
	cmd_t    cmd;
	status_t status;

	ims_controller u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.last_key(item.last_key),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy)
	);

	ims_datapath #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.KEY_BITS    (KEY_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.result      (result),
		.result_valid(result_valid)
	);

	`IMS_ASSERT_NOW(a_result_while_busy, clk, arst_n, result_valid, busy, "result outside sort")
	`IMS_ASSERT_NEXT(a_load_stays_idle, clk, arst_n, start && !busy && !item.last_key, !busy, "load left idle")
	`IMS_ASSERT_NEXT(a_last_starts_sort, clk, arst_n, start && !busy && item.last_key, busy, "sort not started")
	`IMS_ASSERT_NEXT(a_last_ends_run, clk, arst_n, result_valid && result.last_position, !result_valid, "result after last")
endmodule

// ----- hw/rtl/ims_datapath.sv -----
// Datapath of the argsort engine: key and position memories, counters and rank compare.
`timescale 1ns / 1ps
module ims_datapath import ims_pkg::*; #(
	parameter int MAX_ELEMENTS = MaxElements,
	parameter int KEY_BITS = KeyBits
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	input  cmd_t      cmd,
	output status_t   status,
	output out_item_t result,
	output logic      result_valid
);
	localparam int SW = (KEY_BITS < 16) ? KEY_BITS : 16;
	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	logic [SW-1:0] kmem [MAX_ELEMENTS];
	logic [AW-1:0] pmem [MAX_ELEMENTS];
	logic [CW-1:0] count_q;
	logic [AW-1:0] i_q, j_q, k_q, rank_q;
	logic [SW-1:0] krd_s1, cur_q;
	logic [AW-1:0] jidx_s1, prd_s1;
	logic          cmp_s1, ovalid_s1, olast_s1;
	logic          full, less;
	logic [CW-1:0] n_last;

	assign full = (count_q == CW'(MAX_ELEMENTS));
	assign n_last = count_q - 1'b1;
	assign status.i_end = (CW'(i_q) == n_last);
	assign status.j_end = (CW'(j_q) == n_last);
	assign status.k_end = (CW'(k_q) == n_last);
	assign less = (krd_s1 < cur_q) || ((krd_s1 == cur_q) && (jidx_s1 < i_q));

	always_ff @(posedge clk) begin
		if (cmd.key_wr && !full) begin
			kmem[count_q[AW-1:0]] <= item.key[SW-1:0];
		end
		if (cmd.rd_i) begin
			krd_s1 <= kmem[i_q];
		end else if (cmd.rd_j) begin
			krd_s1 <= kmem[j_q];
		end
		if (cmd.pos_wr) begin
			pmem[rank_q] <= i_q;
		end
		if (cmd.out_rd) begin
			prd_s1 <= pmem[k_q];
		end
		if (cmd.load_cur) begin
			cur_q <= krd_s1;
		end
		jidx_s1 <= j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			rank_q <= '0;
			cmp_s1 <= 1'b0;
			ovalid_s1 <= 1'b0;
			olast_s1 <= 1'b0;
		end else begin
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.key_wr && !full) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.clr_i) begin
				i_q <= '0;
			end else if (cmd.inc_i) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.clr_j) begin
				j_q <= '0;
			end else if (cmd.inc_j) begin
				j_q <= j_q + 1'b1;
			end
			if (cmd.clr_k) begin
				k_q <= '0;
			end else if (cmd.inc_k) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.clr_rank) begin
				rank_q <= '0;
			end else if (cmp_s1 && less) begin
				rank_q <= rank_q + 1'b1;
			end
			cmp_s1 <= cmd.rd_j;
			ovalid_s1 <= cmd.out_rd;
			olast_s1 <= cmd.out_rd && status.k_end;
		end
	end

	assign result.position = 6'(prd_s1);
	assign result.last_position = olast_s1;
	assign result_valid = ovalid_s1;
endmodule

// ----- hw/rtl/ims_controller.sv -----
// Controller state machine of the argsort engine.
`timescale 1ns / 1ps
module ims_controller import ims_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    last_key,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RDI    = 3'd1;
	localparam logic [2:0] S_LATI   = 3'd2;
	localparam logic [2:0] S_SWEEP  = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_WRITE  = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;
	localparam logic [2:0] S_ODRAIN = 3'd7;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.clr_i = 1'b1;
				if (start) begin
					cmd.key_wr = 1'b1;
					if (last_key) begin
						state_d = S_RDI;
					end
				end
			end
			S_RDI: begin
				cmd.rd_i = 1'b1;
				cmd.clr_j = 1'b1;
				cmd.clr_rank = 1'b1;
				state_d = S_LATI;
			end
			S_LATI: begin
				cmd.load_cur = 1'b1;
				state_d = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.rd_j = 1'b1;
				cmd.inc_j = 1'b1;
				if (status.j_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.pos_wr = 1'b1;
				cmd.inc_i = 1'b1;
				cmd.clr_k = 1'b1;
				state_d = status.i_end ? S_OUT : S_RDI;
			end
			S_OUT: begin
				cmd.out_rd = 1'b1;
				cmd.inc_k = 1'b1;
				if (status.k_end) begin
					state_d = S_ODRAIN;
				end
			end
			S_ODRAIN: begin
				cmd.clr_count = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the argsort engine: directed and random key sets checked against a local predictor.
`timescale 1ns / 1ps
module tb;
	import ims_pkg::*;

	localparam int WatchdogLimit = 200000;
	localparam int NumDirected = 18;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	out_item_t result;
	logic      result_valid;

	index_merge_sort dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result(result),
		.result_valid(result_valid)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	logic [15:0] held_keys[MaxElements];
	int          held_count;
	out_item_t   pending_positions[$];
	int          mismatches;
	int          results_seen;
	int          sets_closed;
	int          idle_cycles;
	bit          timed_out;

	// Stable argsort of the held keys; queues one result per held key.
	task automatic rank_held_keys();
		logic [5:0] order[MaxElements];
		int         j;
		logic [5:0] cur;
		out_item_t  r;
		for (int i = 0; i < held_count; i++) begin
			cur = 6'(i);
			j = i;
			while (j > 0 && held_keys[order[j - 1]] > held_keys[i]) begin
				order[j] = order[j - 1];
				j--;
			end
			order[j] = cur;
		end
		for (int k = 0; k < held_count; k++) begin
			r.position = order[k];
			r.last_position = (k == held_count - 1);
			pending_positions.push_back(r);
		end
		held_count = 0;
		sets_closed++;
	endtask

	task automatic record_key(input in_item_t it);
		if (held_count < MaxElements) begin
			held_keys[held_count] = it.key;
			held_count++;
		end
		if (it.last_key)
			rank_held_keys();
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid) begin
			results_seen++;
			if (pending_positions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result position=%0d last=%0b",
						result.position, result.last_position);
			end else begin
				want = pending_positions.pop_front();
				if (want.position !== result.position ||
						want.last_position !== result.last_position) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected pos=%0d last=%0b, got pos=%0d last=%0b",
							want.position, want.last_position,
							result.position, result.last_position);
				end
			end
		end
	end

	// The watchdog counts cycles with no transfer on either side.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	int burst_left;

	// Drives one key, with random gaps between bursts, and waits for its transfer.
	task automatic send_key(input logic [15:0] k, input logic lst);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		start <= 1'b1;
		item.key <= k;
		item.last_key <= lst;
		@(posedge clk);
		while (busy) begin
			if (idle_cycles > WatchdogLimit) begin
				timed_out = 1;
				return;
			end
			@(posedge clk);
		end
		record_key('{key: k, last_key: lst});
		burst_left--;
	endtask

	task automatic send_set(input int n, input int key_span);
		for (int i = 0; i < n && !timed_out; i++)
			send_key(16'($urandom_range(0, key_span)), i == n - 1);
	endtask

	logic [15:0] dir_key[NumDirected] = '{
		16'h0000, 16'hffff,
		16'hffff, 16'h0000, 16'h8000,
		16'h0005, 16'h0005, 16'h0005,
		16'h1234,
		16'haaaa, 16'h5555, 16'h0001, 16'hfffe, 16'h0000,
		16'h7fff, 16'h8001, 16'h7fff, 16'h0000
	};
	logic dir_last[NumDirected] = '{
		1'b0, 1'b1,
		1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b1,
		1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1
	};

	initial begin
		int total;
		int span;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		held_count = 0;
		mismatches = 0;
		results_seen = 0;
		sets_closed = 0;
		timed_out = 0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NumDirected && !timed_out; i++)
			send_key(dir_key[i], dir_last[i]);

		// A full store with overflow keys that must be dropped.
		for (int i = 0; i < MaxElements + 3 && !timed_out; i++)
			send_key(16'($urandom), i == MaxElements + 2);

		total = 0;
		while (total < 400 && !timed_out) begin
			int n;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
			span = ($urandom_range(0, 1) == 0) ? 7 : 65535;
			send_set(n, span);
			total += n;
		end
		start <= 1'b0;

		while (pending_positions.size() != 0 && !timed_out) begin
			if (idle_cycles > WatchdogLimit)
				timed_out = 1;
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		if (timed_out) begin
			$display("tb: done, errors");
			$finish;
		end
		$display("covered %0d sorted sets, %0d positions checked, including a full store",
			sets_closed, results_seen);
		if (mismatches == 0 && pending_positions.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
